@@ rtl/htw_pkg.sv @@
// Shared types, codes and defaults for the hierarchical timer wheel.
package htw_pkg;

  // Default sizing
  localparam int NUM_TIMERS_DEF = 32;
  localparam int WHEEL_BITS_DEF = 8;

  // Entry pointers are 6 bits wide; all ones marks an empty link
  localparam int IDW = 6;
  localparam logic [IDW-1:0] NIL = 6'h3f;

  // Input actions
  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_DEL  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;
  localparam logic [1:0] ACT_ADJ  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Sources of the timer number in a result
  localparam logic [1:0] SRC_ID    = 2'd0;
  localparam logic [1:0] SRC_ENTRY = 2'd1;
  localparam logic [1:0] SRC_ZERO  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [4:0]  timer_id;
    logic [30:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] which_timer;
    logic       status;
    logic       last;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       clr_wr;
    logic       bidx_clr;
    logic       bidx_inc;
    logic       bidx_casc;
    logic       lvl_clr;
    logic       lvl_inc;
    logic       now_inc;
    logic       now_adj;
    logic       bh_rd;
    logic       ent_rd;
    logic       e_head;
    logic       e_todo;
    logic       unlink;
    logic       add_due;
    logic       adj_due;
    logic       set_q;
    logic       clr_q;
    logic       l_todo;
    logic       l_pick;
    logic       ap0;
    logic       ap1;
    logic       ap2;
    logic       rel_ld;
    logic       emit;
    logic [1:0] emit_kind;
    logic [1:0] emit_src;
    logic       emit_status;
    logic       emit_last;
  } htw_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] action;
    logic       amt_zero;
    logic       id_ok;
    logic       q_item;
    logic       earlier;
    logic       bh_valid;
    logic       todo_valid;
    logic       tail_valid;
    logic       fire;
    logic       next_level;
    logic       bidx_last;
    logic       out_free;
  } htw_sts_t;

endpackage

@@ rtl/htw_dp.sv @@
// Datapath of the timer wheel: list memories, time counter, output register.
module htw_dp import htw_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int WHEEL_BITS = WHEEL_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  logic      in_take,
  input  htw_cmd_t  cmd,
  output htw_sts_t  sts,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int WSIZE = 1 << WHEEL_BITS;
  localparam int NB    = 4 * WSIZE;
  localparam int BW    = WHEEL_BITS + 2;
  localparam int LW    = WHEEL_BITS + 3;
  localparam int AW    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [LW-1:0]  TODO_L = LW'(NB);
  localparam logic [IDW-1:0] NT_ID  = IDW'(NUM_TIMERS);
  localparam logic [BW-1:0]  B_LAST = BW'(NB - 1);
  localparam logic [32:0]    LIM0   = 33'(WSIZE);
  localparam logic [32:0]    LIM1   = 33'(1) << (2 * WHEEL_BITS);
  localparam logic [32:0]    LIM2   = 33'(1) << (3 * WHEEL_BITS);

  function automatic logic [WHEEL_BITS-1:0] slot_of(input logic [1:0] lv,
                                                    input logic [31:0] t);
    logic [WHEEL_BITS-1:0] s;
    case (lv)
      2'd0:    s = t[0 +: WHEEL_BITS];
      2'd1:    s = t[WHEEL_BITS +: WHEEL_BITS];
      2'd2:    s = t[2*WHEEL_BITS +: WHEEL_BITS];
      default: s = t[3*WHEEL_BITS +: WHEEL_BITS];
    endcase
    return s;
  endfunction

  // Control and working registers
  in_item_t              item_r;
  logic [31:0]           now_r;
  logic [IDW-1:0]        todo_head_r, todo_tail_r;
  logic [NUM_TIMERS-1:0] queued_r;
  logic [IDW-1:0]        e_r, old_r;
  logic [BW-1:0]         bidx_r;
  logic [1:0]            lvl_r;
  logic [LW-1:0]         lst_r;
  logic [31:0]           rel_r;
  out_item_t             out_r;
  logic                  out_valid_r;

  // Memories and their read registers
  logic [IDW-1:0] bhead_mem [NB];
  logic [IDW-1:0] btail_mem [NB];
  logic [IDW-1:0] next_mem [NUM_TIMERS];
  logic [IDW-1:0] prev_mem [NUM_TIMERS];
  logic [31:0]    due_mem [NUM_TIMERS];
  logic [LW-1:0]  list_mem [NUM_TIMERS];
  logic [IDW-1:0] bh_rd_r, bt_rd_r, nx_rd_r, pv_rd_r;
  logic [31:0]    du_rd_r;
  logic [LW-1:0]  ls_rd_r;

  logic [AW-1:0] ea;
  logic [31:0]   amt32, now_plus, old_rel;
  logic          p_ok, n_ok, l_todo, lst_todo, old_ok;
  logic [IDW-1:0] app_old;
  logic          adj_cond;
  logic [32:0]   rel33;
  logic [1:0]    plv;
  logic [LW-1:0] pick_l;

  assign ea       = e_r[AW-1:0];
  assign amt32    = {1'b0, item_r.amount};
  assign now_plus = now_r + amt32;
  assign old_rel  = du_rd_r - now_r;
  assign p_ok     = pv_rd_r < NT_ID;
  assign n_ok     = nx_rd_r < NT_ID;
  assign l_todo   = ls_rd_r == TODO_L;
  assign lst_todo = lst_r == TODO_L;
  assign app_old  = lst_todo ? todo_tail_r : bt_rd_r;
  assign old_ok   = old_r < NT_ID;
  assign adj_cond = $signed(old_rel) < $signed(amt32);

  // Bucket choice by wrapped distance
  assign rel33 = {1'b0, rel_r};
  always_comb begin
    if (rel33 <= LIM1) plv = (rel33 <= LIM0) ? 2'd0 : 2'd1;
    else if (rel33 <= LIM2) plv = 2'd2;
    else plv = 2'd3;
  end
  assign pick_l = {1'b0, plv, slot_of(plv, du_rd_r)};

  // Write port selection for each memory
  logic           nx_we, pv_we, du_we, ls_we, bh_we, bt_we;
  logic [AW-1:0]  nx_wa, pv_wa;
  logic [IDW-1:0] nx_wd, pv_wd, bh_wd, bt_wd;
  logic [BW-1:0]  bh_wa, bt_wa;

  always_comb begin
    nx_we = 1'b0; nx_wa = ea; nx_wd = NIL;
    pv_we = 1'b0; pv_wa = ea; pv_wd = app_old;
    bh_we = 1'b0; bh_wa = bidx_r; bh_wd = NIL;
    bt_we = 1'b0; bt_wa = bidx_r; bt_wd = NIL;
    if (cmd.clr_wr) begin
      bh_we = 1'b1;
      bt_we = 1'b1;
    end
    if (cmd.unlink) begin
      if (p_ok) begin
        nx_we = 1'b1; nx_wa = pv_rd_r[AW-1:0]; nx_wd = nx_rd_r;
      end else if (!l_todo) begin
        bh_we = 1'b1; bh_wa = ls_rd_r[BW-1:0]; bh_wd = nx_rd_r;
      end
      if (n_ok) begin
        pv_we = 1'b1; pv_wa = nx_rd_r[AW-1:0]; pv_wd = pv_rd_r;
      end else if (!l_todo) begin
        bt_we = 1'b1; bt_wa = ls_rd_r[BW-1:0]; bt_wd = pv_rd_r;
      end
    end
    if (cmd.ap1) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
      if (!lst_todo) begin
        bt_we = 1'b1; bt_wa = lst_r[BW-1:0]; bt_wd = e_r;
      end
    end
    if (cmd.ap2) begin
      if (old_ok) begin
        nx_we = 1'b1; nx_wa = old_r[AW-1:0]; nx_wd = e_r;
      end else if (!lst_todo) begin
        bh_we = 1'b1; bh_wa = lst_r[BW-1:0]; bh_wd = e_r;
      end
    end
  end

  assign du_we = cmd.add_due || (cmd.adj_due && adj_cond);
  assign ls_we = cmd.ap1;

  // Bucket memories
  always_ff @(posedge clk) begin
    if (bh_we) bhead_mem[bh_wa] <= bh_wd;
    if (bt_we) btail_mem[bt_wa] <= bt_wd;
    if (cmd.bh_rd) bh_rd_r <= bhead_mem[bidx_r];
    if (cmd.ap0) bt_rd_r <= btail_mem[lst_r[BW-1:0]];
  end

  // Entry memories
  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (du_we) due_mem[ea] <= now_plus;
    if (ls_we) list_mem[ea] <= lst_r;
    if (cmd.ent_rd) begin
      nx_rd_r <= next_mem[ea];
      pv_rd_r <= prev_mem[ea];
      du_rd_r <= due_mem[ea];
      ls_rd_r <= list_mem[ea];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) item_r <= in_item;
    if (in_take) e_r <= {1'b0, in_item.timer_id};
    else if (cmd.e_head) e_r <= bh_rd_r;
    else if (cmd.e_todo) e_r <= todo_head_r;
    if (cmd.l_todo) lst_r <= TODO_L;
    else if (cmd.l_pick) lst_r <= pick_l;
    if (cmd.ap1) old_r <= app_old;
    if (cmd.rel_ld) rel_r <= old_rel;
    if (cmd.emit) begin
      out_r.kind   <= cmd.emit_kind;
      out_r.status <= cmd.emit_status;
      out_r.last   <= cmd.emit_last;
      case (cmd.emit_src)
        SRC_ID:    out_r.which_timer <= item_r.timer_id;
        SRC_ENTRY: out_r.which_timer <= e_r[4:0];
        default:   out_r.which_timer <= 5'd0;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= 32'd0;
      todo_head_r <= NIL;
      todo_tail_r <= NIL;
      queued_r    <= '0;
      bidx_r      <= '0;
      lvl_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.now_inc) now_r <= now_r + 32'd1;
      else if (cmd.now_adj) now_r <= now_plus;
      // to-do list ends
      if (cmd.unlink && !p_ok && l_todo) todo_head_r <= nx_rd_r;
      else if (cmd.ap2 && !old_ok && lst_todo) todo_head_r <= e_r;
      if (cmd.unlink && !n_ok && l_todo) todo_tail_r <= pv_rd_r;
      else if (cmd.ap1 && lst_todo) todo_tail_r <= e_r;
      if (cmd.set_q) queued_r[ea] <= 1'b1;
      else if (cmd.clr_q) queued_r[ea] <= 1'b0;
      if (cmd.bidx_clr) bidx_r <= '0;
      else if (cmd.bidx_inc) bidx_r <= bidx_r + BW'(1);
      else if (cmd.bidx_casc) bidx_r <= {lvl_r, slot_of(lvl_r, now_r)};
      if (cmd.lvl_clr) lvl_r <= 2'd0;
      else if (cmd.lvl_inc) lvl_r <= lvl_r + 2'd1;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Status back to the controller
  always_comb begin
    sts.action     = item_r.action;
    sts.amt_zero   = item_r.amount == 31'd0;
    sts.id_ok      = e_r < NT_ID;
    sts.q_item     = sts.id_ok && queued_r[ea];
    sts.earlier    = $signed(amt32) < $signed(old_rel);
    sts.bh_valid   = bh_rd_r < NT_ID;
    sts.todo_valid = todo_head_r < NT_ID;
    sts.tail_valid = todo_tail_r < NT_ID;
    sts.fire       = !((rel_r != 32'd0) && !rel_r[31]);
    sts.next_level = (lvl_r != 2'd3) && (slot_of(lvl_r, now_r) == '0);
    sts.bidx_last  = bidx_r == B_LAST;
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

@@ rtl/htw_ctrl.sv @@
// Sequencer of the timer wheel: list moves, cascade, drain and result issue.
module htw_ctrl import htw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  htw_sts_t sts,
  output htw_cmd_t cmd
);

  localparam logic [4:0] ST_CLR     = 5'd0;
  localparam logic [4:0] ST_IDLE    = 5'd1;
  localparam logic [4:0] ST_DISP    = 5'd2;
  localparam logic [4:0] ST_ADD1    = 5'd3;
  localparam logic [4:0] ST_DEL1    = 5'd4;
  localparam logic [4:0] ST_ACK     = 5'd5;
  localparam logic [4:0] ST_ADJ_BH  = 5'd6;
  localparam logic [4:0] ST_ADJ_CHK = 5'd7;
  localparam logic [4:0] ST_ADJ_ERD = 5'd8;
  localparam logic [4:0] ST_ADJ_POP = 5'd9;
  localparam logic [4:0] ST_CAS_B   = 5'd10;
  localparam logic [4:0] ST_CAS_BH  = 5'd11;
  localparam logic [4:0] ST_CAS_CHK = 5'd12;
  localparam logic [4:0] ST_CAS_ERD = 5'd13;
  localparam logic [4:0] ST_CAS_POP = 5'd14;
  localparam logic [4:0] ST_DR_CHK  = 5'd15;
  localparam logic [4:0] ST_DR_ERD  = 5'd16;
  localparam logic [4:0] ST_DR_EV   = 5'd17;
  localparam logic [4:0] ST_DR_DEC  = 5'd18;
  localparam logic [4:0] ST_AP0     = 5'd19;
  localparam logic [4:0] ST_AP1     = 5'd20;
  localparam logic [4:0] ST_AP2     = 5'd21;

  logic [4:0] st_r, st_nxt, ret_r, ret_nxt;
  logic       ack_st_r, ack_st_nxt;
  logic [1:0] ack_src_r, ack_src_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_CLR;
      ret_r     <= ST_IDLE;
      ack_st_r  <= 1'b0;
      ack_src_r <= SRC_ID;
    end else begin
      st_r      <= st_nxt;
      ret_r     <= ret_nxt;
      ack_st_r  <= ack_st_nxt;
      ack_src_r <= ack_src_nxt;
    end
  end

  assign in_ready = st_r == ST_IDLE;

  // Next state and commands
  always_comb begin
    st_nxt      = st_r;
    ret_nxt     = ret_r;
    ack_st_nxt  = ack_st_r;
    ack_src_nxt = ack_src_r;
    cmd         = '0;
    case (st_r)
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.bidx_last) begin
          cmd.bidx_clr = 1'b1;
          st_nxt = ST_IDLE;
        end else begin
          cmd.bidx_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) st_nxt = ST_DISP;
      end
      ST_DISP: begin
        ack_st_nxt  = 1'b0;
        ack_src_nxt = SRC_ID;
        case (sts.action)
          ACT_ADD: begin
            if (sts.id_ok) begin
              cmd.ent_rd = 1'b1;
              st_nxt = ST_ADD1;
            end else begin
              st_nxt = ST_ACK;
            end
          end
          ACT_DEL: begin
            if (sts.q_item) begin
              cmd.ent_rd = 1'b1;
              st_nxt = ST_DEL1;
            end else begin
              st_nxt = ST_ACK;
            end
          end
          ACT_ADJ: begin
            ack_src_nxt = SRC_ZERO;
            if (sts.amt_zero) begin
              st_nxt = ST_ACK;
            end else begin
              cmd.bidx_clr = 1'b1;
              st_nxt = ST_ADJ_BH;
            end
          end
          default: begin
            cmd.now_inc = 1'b1;
            cmd.lvl_clr = 1'b1;
            st_nxt = ST_CAS_B;
          end
        endcase
      end
      ST_ADD1: begin
        cmd.add_due = 1'b1;
        ret_nxt = ST_ACK;
        if (!sts.q_item) begin
          cmd.set_q  = 1'b1;
          cmd.l_todo = 1'b1;
          ack_st_nxt = 1'b1;
          st_nxt = ST_AP0;
        end else if (sts.earlier) begin
          cmd.unlink = 1'b1;
          cmd.l_todo = 1'b1;
          st_nxt = ST_AP0;
        end else begin
          st_nxt = ST_ACK;
        end
      end
      ST_DEL1: begin
        cmd.unlink = 1'b1;
        cmd.clr_q  = 1'b1;
        ack_st_nxt = 1'b1;
        st_nxt = ST_ACK;
      end
      ST_ACK: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_kind   = KIND_ACK;
          cmd.emit_src    = ack_src_r;
          cmd.emit_status = ack_st_r;
          cmd.emit_last   = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      // Adjust: sweep every bucket into the to-do list
      ST_ADJ_BH: begin
        cmd.bh_rd = 1'b1;
        st_nxt = ST_ADJ_CHK;
      end
      ST_ADJ_CHK: begin
        if (sts.bh_valid) begin
          cmd.e_head = 1'b1;
          st_nxt = ST_ADJ_ERD;
        end else if (sts.bidx_last) begin
          cmd.now_adj = 1'b1;
          st_nxt = ST_ACK;
        end else begin
          cmd.bidx_inc = 1'b1;
          st_nxt = ST_ADJ_BH;
        end
      end
      ST_ADJ_ERD: begin
        cmd.ent_rd = 1'b1;
        st_nxt = ST_ADJ_POP;
      end
      ST_ADJ_POP: begin
        cmd.adj_due = 1'b1;
        cmd.unlink  = 1'b1;
        cmd.l_todo  = 1'b1;
        ret_nxt = ST_ADJ_BH;
        st_nxt = ST_AP0;
      end
      // Tick: cascade the due buckets level by level
      ST_CAS_B: begin
        cmd.bidx_casc = 1'b1;
        st_nxt = ST_CAS_BH;
      end
      ST_CAS_BH: begin
        cmd.bh_rd = 1'b1;
        st_nxt = ST_CAS_CHK;
      end
      ST_CAS_CHK: begin
        if (sts.bh_valid) begin
          cmd.e_head = 1'b1;
          st_nxt = ST_CAS_ERD;
        end else if (sts.next_level) begin
          cmd.lvl_inc = 1'b1;
          st_nxt = ST_CAS_B;
        end else begin
          st_nxt = ST_DR_CHK;
        end
      end
      ST_CAS_ERD: begin
        cmd.ent_rd = 1'b1;
        st_nxt = ST_CAS_POP;
      end
      ST_CAS_POP: begin
        cmd.unlink = 1'b1;
        cmd.l_todo = 1'b1;
        ret_nxt = ST_CAS_BH;
        st_nxt = ST_AP0;
      end
      // Tick: drain the to-do list
      ST_DR_CHK: begin
        if (sts.todo_valid) begin
          cmd.e_todo = 1'b1;
          st_nxt = ST_DR_ERD;
        end else if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_TICK;
          cmd.emit_src  = SRC_ZERO;
          cmd.emit_last = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      ST_DR_ERD: begin
        cmd.ent_rd = 1'b1;
        st_nxt = ST_DR_EV;
      end
      ST_DR_EV: begin
        cmd.unlink = 1'b1;
        cmd.rel_ld = 1'b1;
        st_nxt = ST_DR_DEC;
      end
      ST_DR_DEC: begin
        if (!sts.fire) begin
          cmd.l_pick = 1'b1;
          ret_nxt = ST_DR_CHK;
          st_nxt = ST_AP0;
        end else if (sts.out_free) begin
          cmd.clr_q     = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_FIRED;
          cmd.emit_src  = SRC_ENTRY;
          st_nxt = ST_DR_CHK;
        end
      end
      // Append the current entry at the tail of the chosen list
      ST_AP0: begin
        cmd.ap0 = 1'b1;
        st_nxt = ST_AP1;
      end
      ST_AP1: begin
        cmd.ap1 = 1'b1;
        st_nxt = ST_AP2;
      end
      ST_AP2: begin
        cmd.ap2 = 1'b1;
        st_nxt = ret_r;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/hierarchical_timer_wheel.sv @@
// Hierarchical timer wheel: four levels of 2^WHEEL_BITS buckets plus a to-do list,
// with all timers chained in doubly linked lists held in on-chip memories. After
// reset the block first clears all 4*2^WHEEL_BITS buckets (1024 by default), one
// bucket a cycle, before in_ready rises. One item is worked at a time by a sequencer
// that makes one memory access per list per cycle: an add or delete works on one timer,
// a tick cascades the due buckets, moves their timers and drains the to-do list, and
// an adjust sweeps every bucket and moves each timer found into the to-do list. Each
// result waits in an output register, and a fired result stalls the drain until it is taken.
module hierarchical_timer_wheel import htw_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int WHEEL_BITS = WHEEL_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  htw_cmd_t cmd;
  htw_sts_t sts;
  logic     in_take;

  assign in_take = in_valid && in_ready;

  // Sequencer
  htw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Lists, time and result register
  htw_dp #(
    .NUM_TIMERS (NUM_TIMERS),
    .WHEEL_BITS (WHEEL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .in_take   (in_take),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // Between items, both ends of the to-do list are empty together
  a_todo_ends: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (sts.todo_valid == sts.tail_valid))
    else $error("to-do list head and tail disagree");

  // Only fired results leave the item open
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.last == (out_item.kind != KIND_FIRED)))
    else $error("last flag does not match result kind");

  // An accepted item takes the sequencer out of idle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

endmodule

@@ verif/tb_hierarchical_timer_wheel.sv @@
// Self-checking testbench for the hierarchical timer wheel: random and directed timer traffic.
`timescale 1ns / 100ps
module tb_hierarchical_timer_wheel;
  import htw_pkg::*;

  localparam int NT = 32;
  localparam int WB = 8;
  localparam int WS = 1 << WB;
  localparam int NB = 4 * WS;
  localparam int TODO_LIST = 1024;

  // Mirror of the timer wheel, with its own copy of the state
  class wheel_scoreboard;
    bit [31:0] now;
    bit [5:0] bhead [NB];
    bit [5:0] btail [NB];
    bit [5:0] thead, ttail;
    bit [5:0] nxt [NT];
    bit [5:0] prv [NT];
    bit [31:0] due [NT];
    int lst [NT];
    bit queued [NT];
    out_item_t pending [$];
    int errors;

    function void clear();
      now = 0;
      for (int b = 0; b < NB; b++) begin
        bhead[b] = NIL;
        btail[b] = NIL;
      end
      thead = NIL;
      ttail = NIL;
      for (int i = 0; i < NT; i++) begin
        nxt[i] = 0;
        prv[i] = 0;
        due[i] = 0;
        lst[i] = 0;
        queued[i] = 0;
      end
      pending.delete();
      errors = 0;
    endfunction

    function void set_head(int l, bit [5:0] v);
      if (l < NB) bhead[l] = v; else thead = v;
    endfunction

    function void set_tail(int l, bit [5:0] v);
      if (l < NB) btail[l] = v; else ttail = v;
    endfunction

    function void unlink(int id);
      bit [5:0] p;
      bit [5:0] n;
      p = prv[id];
      n = nxt[id];
      if (p < NT) nxt[p] = n; else set_head(lst[id], n);
      if (n < NT) prv[n] = p; else set_tail(lst[id], p);
      nxt[id] = NIL;
      prv[id] = NIL;
    endfunction

    function void append(int id, int l);
      bit [5:0] old;
      old = (l < NB) ? btail[l] : ttail;
      prv[id] = old;
      nxt[id] = NIL;
      if (old < NT) nxt[old] = 6'(id); else set_head(l, 6'(id));
      set_tail(l, 6'(id));
      lst[id] = l;
    endfunction

    function void sweep_bucket(int b);
      int id;
      while (bhead[b] < NT) begin
        id = bhead[b];
        unlink(id);
        append(id, TODO_LIST);
      end
    endfunction

    function bit slt(bit [31:0] a, bit [31:0] b);
      return $signed(a) < $signed(b);
    endfunction

    function int slot(int lvl, bit [31:0] t);
      return (t >> (lvl * WB)) & (WS - 1);
    endfunction

    function int bucket_for(bit [31:0] rel, bit [31:0] d);
      if (rel <= (32'd1 << (2 * WB))) begin
        if (rel <= WS) return slot(0, d);
        return slot(1, d) + WS;
      end
      if (rel <= (32'd1 << (3 * WB))) return slot(2, d) + 2 * WS;
      return slot(3, d) + 3 * WS;
    endfunction

    function void push(logic [1:0] k, int w, bit s, bit l);
      out_item_t r;
      r.kind = k;
      r.which_timer = w[4:0];
      r.status = s;
      r.last = l;
      pending.push_back(r);
    endfunction

    // Work out the results of one accepted item
    function void note_item(in_item_t it);
      int id;
      bit st;
      bit [31:0] amt;
      bit [31:0] nd;
      bit [31:0] old;
      bit [31:0] rel;
      int e;
      id = it.timer_id;
      amt = {1'b0, it.amount};
      st = 0;
      case (it.action)
        ACT_ADD: begin
          if (id < NT) begin
            old = due[id];
            nd = now + amt;
            due[id] = nd;
            if (queued[id]) begin
              if (slt(nd - now, old - now)) begin
                unlink(id);
                append(id, TODO_LIST);
              end
            end else begin
              queued[id] = 1;
              append(id, TODO_LIST);
              st = 1;
            end
          end
          push(KIND_ACK, id, st, 1);
        end
        ACT_DEL: begin
          if (id < NT && queued[id]) begin
            unlink(id);
            queued[id] = 0;
            st = 1;
          end
          push(KIND_ACK, id, st, 1);
        end
        ACT_ADJ: begin
          if (amt != 0) begin
            nd = now + amt;
            for (int b = 0; b < NB; b++) begin
              while (bhead[b] < NT) begin
                e = bhead[b];
                if (slt(due[e] - now, amt)) due[e] = nd;
                unlink(e);
                append(e, TODO_LIST);
              end
            end
            now = nd;
          end
          push(KIND_ACK, 0, 0, 1);
        end
        default: begin
          now = now + 1;
          sweep_bucket(slot(0, now));
          if (slot(0, now) == 0) begin
            sweep_bucket(slot(1, now) + WS);
            if (slot(1, now) == 0) begin
              sweep_bucket(slot(2, now) + 2 * WS);
              if (slot(2, now) == 0) sweep_bucket(slot(3, now) + 3 * WS);
            end
          end
          while (thead < NT) begin
            e = thead;
            rel = due[e] - now;
            unlink(e);
            if (rel != 0 && !rel[31]) append(e, bucket_for(rel, due[e]));
            else begin
              queued[e] = 0;
              push(KIND_FIRED, e, 0, 0);
            end
          end
          push(KIND_TICK, 0, 0, 1);
        end
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t w;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      w = pending.pop_front();
      if (got.kind !== w.kind) report($sformatf("kind %0d want %0d", got.kind, w.kind));
      if (got.which_timer !== w.which_timer)
        report($sformatf("timer %0d want %0d", got.which_timer, w.which_timer));
      if (got.status !== w.status) report($sformatf("status %0b want %0b", got.status, w.status));
      if (got.last !== w.last) report($sformatf("last %0b want %0b", got.last, w.last));
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_item_t in_item;
  out_item_t out_item;
  wheel_scoreboard sb;
  bit no_idle;
  int hold_cycles;

  hierarchical_timer_wheel uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Overall time limit
  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Send one item, with random idle before it
  task automatic send(logic [1:0] act, int id, bit [30:0] amt);
    in_item_t it;
    while (!no_idle && $urandom_range(99) < 10) begin
      in_valid <= 0;
      @(posedge clk);
    end
    it.action = act;
    it.timer_id = id[4:0];
    it.amount = amt;
    in_valid <= 1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
  endtask

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_item);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 0;
      end else out_ready <= no_idle || ($urandom_range(99) >= 10);
    end
  end

  function automatic bit [30:0] rand_delay();
    case ($urandom_range(9))
      0: return 31'($urandom_range(300, 70000));
      1: return 31'($urandom & 32'h7fffffff);
      2: return 0;
      default: return 31'($urandom_range(1, 300));
    endcase
  endfunction

  initial begin
    int r;
    int waited;
    sb = new();
    sb.clear();
    rst_n = 0;
    in_valid = 0;
    in_item = '0;
    hold_cycles = 0;
    no_idle = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: field extremes, each action, special cases
    send(ACT_ADD, 0, 0);
    send(ACT_ADD, 31, 31'h7fffffff);
    send(ACT_ADD, 5, 3);
    send(ACT_ADD, 5, 10);
    send(ACT_ADD, 6, 20);
    send(ACT_ADD, 6, 1);
    send(ACT_DEL, 7, 0);
    send(ACT_TICK, 0, 0);
    send(ACT_ADD, 9, 600);
    send(ACT_ADD, 10, 70000);
    send(ACT_ADD, 11, 20000000);
    send(ACT_TICK, 0, 0);
    send(ACT_ADJ, 0, 0);
    send(ACT_ADJ, 0, 1000);
    send(ACT_TICK, 0, 0);
    send(ACT_DEL, 31, 0);
    send(ACT_DEL, 31, 31'h7fffffff);
    send(ACT_ADJ, 0, 31'h7fffffff);
    send(ACT_TICK, 31, 31'h7fffffff);
    send(ACT_ADJ, 0, 31'h7ffffff0);
    send(ACT_TICK, 0, 0);
    send(ACT_TICK, 0, 0);

    // Long receiver hold-off while items keep coming
    hold_cycles = 400;
    for (int i = 0; i < 12; i++) send(ACT_ADD, i, 0);
    send(ACT_TICK, 0, 0);
    for (int i = 0; i < 8; i++) send(ACT_TICK, 0, 0);

    // Random traffic, mostly adds and ticks; a stretch with no idling
    for (int i = 0; i < 380; i++) begin
      no_idle = (i >= 150 && i < 230);
      r = $urandom_range(99);
      if (r < 40) send(ACT_ADD, $urandom_range(31), rand_delay());
      else if (r < 55) send(ACT_DEL, $urandom_range(31), 31'($urandom & 32'h7fffffff));
      else if (r < 95) send(ACT_TICK, $urandom_range(31), 31'($urandom & 32'h7fffffff));
      else send(ACT_ADJ, $urandom_range(31),
                $urandom_range(3) == 0 ? 31'($urandom & 32'h7fffffff)
                                       : 31'($urandom_range(0, 600)));
    end
    no_idle = 0;
    in_valid <= 0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/htw_pkg.sv
rtl/htw_dp.sv
rtl/htw_ctrl.sv
rtl/hierarchical_timer_wheel.sv
verif/tb_hierarchical_timer_wheel.sv
